// ===== src/cas_pkg.sv =====
// shared constants, types and twiddle table for the cross ambiguity row core
package cas_pkg;

  // transform and store geometry
  localparam int DFT_LEN     = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int POS_W       = 7;
  localparam int CNT_W       = 7;
  localparam int BIN_W       = 6;
  localparam int STEP_SH     = $clog2(64 / DFT_LEN);

  // datapath widths
  localparam int ENERGY_W  = 37;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 33;
  localparam int TW_W      = 16;
  localparam int TERM_W    = 50;
  localparam int ACC_W     = 56;
  localparam int MAG_W     = 40;
  localparam int WIDE_W    = 80;
  localparam int QUO_W     = 16;
  localparam int MUL_STEPS = 40;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DEN,
    ST_MAC,
    ST_RND,
    ST_SQR,
    ST_SQI,
    ST_DIV,
    ST_OUT
  } cas_state_t;

  // operand select of the serial multiplier
  typedef enum logic [1:0] {
    MUL_DEN,
    MUL_RE,
    MUL_IM
  } cas_mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic               in_take;
    logic               prod_wr;
    logic               mac_clr;
    logic               mac_issue;
    logic [ADDR_W-1:0]  mac_addr;
    logic               rnd;
    logic               mul_load;
    cas_mul_sel_t       mul_sel;
    logic               mul_step;
    logic               den_save;
    logic               p_save;
    logic               p_add;
    logic               div_init;
    logic               div_step;
    logic               out_load;
    logic [BIN_W-1:0]   bin;
    logic               bin_last;
  } cas_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pos_ok;
    logic out_busy;
  } cas_sts_t;

  // first quadrant of the cosine, q1.14
  function automatic logic signed [TW_W-1:0] cas_quarter(input logic [4:0] i);
    case (i)
      5'd0:    return 16'sd16384;
      5'd1:    return 16'sd16305;
      5'd2:    return 16'sd16069;
      5'd3:    return 16'sd15679;
      5'd4:    return 16'sd15137;
      5'd5:    return 16'sd14449;
      5'd6:    return 16'sd13623;
      5'd7:    return 16'sd12665;
      5'd8:    return 16'sd11585;
      5'd9:    return 16'sd10394;
      5'd10:   return 16'sd9102;
      5'd11:   return 16'sd7723;
      5'd12:   return 16'sd6270;
      5'd13:   return 16'sd4756;
      5'd14:   return 16'sd3196;
      5'd15:   return 16'sd1606;
      default: return 16'sd0;
    endcase
  endfunction

  // full-circle cosine from the quarter table
  function automatic logic signed [TW_W-1:0] cas_cos(input logic [5:0] m);
    logic [4:0]             idx;
    logic                   neg;
    logic signed [TW_W-1:0] q;
    if (m <= 6'd16) begin
      idx = m[4:0];
      neg = 1'b0;
    end else if (m <= 6'd32) begin
      idx = 5'(6'd32 - m);
      neg = 1'b1;
    end else if (m <= 6'd48) begin
      idx = 5'(m - 6'd32);
      neg = 1'b1;
    end else begin
      idx = 5'(7'd64 - {1'b0, m});
      neg = 1'b0;
    end
    q = cas_quarter(idx);
    return neg ? -q : q;
  endfunction

endpackage

// ===== src/cas_regs.sv =====
// configuration register file behind the apb-style port
module cas_regs import cas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output logic [ENERGY_W-1:0] ref_energy
);

  logic [ENERGY_W-1:0] ref_energy_r;

  // reference energy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_energy_r <= ENERGY_W'(1);
    end else if (psel && penable && pwrite && !paddr[3]) begin
      ref_energy_r <= pwdata[ENERGY_W-1:0];
    end
  end

  // read back
  assign prdata     = paddr[3] ? 64'd0 : {{(64-ENERGY_W){1'b0}}, ref_energy_r};
  assign pready     = 1'b1;
  assign ref_energy = ref_energy_r;

endmodule

// ===== src/cas_datapath.sv =====
// sample stores, product unit, dft accumulator, serial multiplier and divider
module cas_datapath import cas_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cas_cmd_t                   cmd,
  output cas_sts_t                   sts,
  input  logic                       in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample_re,
  input  logic signed [SAMPLE_W-1:0] in_sample_im,
  input  logic [ENERGY_W-1:0]        in_window_energy,
  input  logic                       in_end_of_window,
  input  logic [ENERGY_W-1:0]        ref_energy,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [BIN_W-1:0]           out_bin_index,
  output logic [QUO_W-1:0]           out_ambiguity,
  output logic                       out_zero_energy,
  output logic                       out_last_bin
);

  // memories
  logic [2*SAMPLE_W-1:0] cutout_mem [STORE_DEPTH];
  logic [2*PROD_W-1:0]   work_mem   [STORE_DEPTH];

  // item side
  logic [POS_W-1:0]           pos_r;
  logic [POS_W-1:0]           pos_inc;
  logic                       pos_ok;
  logic [STORE_DEPTH-1:0]     nz_r;
  logic [STORE_DEPTH-1:0]     keep_mask;
  logic [ENERGY_W-1:0]        held_r;
  logic signed [SAMPLE_W-1:0] smp_re_r;
  logic signed [SAMPLE_W-1:0] smp_im_r;
  logic [ADDR_W-1:0]          prod_addr_r;
  logic [2*SAMPLE_W-1:0]      cut_rd_r;
  logic signed [SAMPLE_W-1:0] cut_re;
  logic signed [SAMPLE_W-1:0] cut_im;
  logic signed [PROD_W-1:0]   prod_re;
  logic signed [PROD_W-1:0]   prod_im;

  // dft pipeline
  logic [2*PROD_W-1:0]        wk_rd_r;
  logic [ADDR_W-1:0]          n_d1_r;
  logic                       v1_r;
  logic                       v2_r;
  logic signed [PROD_W-1:0]   w_re;
  logic signed [PROD_W-1:0]   w_im;
  logic [11:0]                kn;
  logic [5:0]                 tw_m;
  logic signed [TW_W-1:0]     tw_c;
  logic signed [TW_W-1:0]     tw_s;
  logic signed [TERM_W-1:0]   t_rc_r;
  logic signed [TERM_W-1:0]   t_is_r;
  logic signed [TERM_W-1:0]   t_ic_r;
  logic signed [TERM_W-1:0]   t_rs_r;
  logic signed [ACC_W-1:0]    xr_r;
  logic signed [ACC_W-1:0]    xi_r;
  logic [MAG_W-1:0]           mr_r;
  logic [MAG_W-1:0]           mi_r;

  // serial multiply and divide
  logic [WIDE_W-1:0]          mul_a_r;
  logic [MAG_W-1:0]           mul_b_r;
  logic [WIDE_W-1:0]          mul_acc_r;
  logic [WIDE_W-1:0]          den_r;
  logic [WIDE_W-1:0]          p_r;
  logic [WIDE_W-1:0]          rem_r;
  logic [WIDE_W:0]            rem_sh;
  logic [QUO_W-1:0]           quo_r;
  logic                       sat_r;

  // result register
  logic                       out_valid_r;
  logic [BIN_W-1:0]           bin_r;
  logic [QUO_W-1:0]           amb_r;
  logic                       zero_r;
  logic                       last_r;

  // rounds the magnitude half away from zero, dropping 14 bits
  function automatic logic [MAG_W-1:0] round_mag(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W:0]   sum;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    sum = {1'b0, mag} + (ACC_W+1)'(8192);
    return MAG_W'(sum >> 14);
  endfunction

  // position bookkeeping
  assign pos_ok  = pos_r < POS_W'(DFT_LEN);
  assign pos_inc = pos_ok ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      keep_mask[i] = POS_W'(i) < pos_inc;
    end
  end

  // control state: position, written flags, held energy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      nz_r   <= '0;
      held_r <= '0;
    end else begin
      if (cmd.in_take) begin
        pos_r <= in_end_of_window ? '0 : pos_inc;
        if (in_op && in_end_of_window) begin
          nz_r   <= nz_r & keep_mask;
          held_r <= in_window_energy;
        end
      end
      if (cmd.prod_wr) begin
        nz_r[prod_addr_r] <= 1'b1;
      end
    end
  end

  // cutout store and sample capture
  always_ff @(posedge clk) begin
    if (cmd.in_take && !in_op && pos_ok) begin
      cutout_mem[pos_r[ADDR_W-1:0]] <= {in_sample_im, in_sample_re};
    end
    cut_rd_r <= cutout_mem[pos_r[ADDR_W-1:0]];
    if (cmd.in_take) begin
      smp_re_r    <= in_sample_re;
      smp_im_r    <= in_sample_im;
      prod_addr_r <= pos_r[ADDR_W-1:0];
    end
  end

  // complex product of sample and cutout
  assign cut_re  = cut_rd_r[SAMPLE_W-1:0];
  assign cut_im  = cut_rd_r[2*SAMPLE_W-1:SAMPLE_W];
  assign prod_re = PROD_W'(smp_re_r * cut_re) - PROD_W'(smp_im_r * cut_im);
  assign prod_im = PROD_W'(smp_re_r * cut_im) + PROD_W'(smp_im_r * cut_re);

  // work store
  always_ff @(posedge clk) begin
    if (cmd.prod_wr) begin
      work_mem[prod_addr_r] <= {prod_im, prod_re};
    end
    wk_rd_r <= work_mem[cmd.mac_addr];
    n_d1_r  <= cmd.mac_addr;
  end

  // twiddle and term products
  assign w_re = nz_r[n_d1_r] ? wk_rd_r[PROD_W-1:0] : '0;
  assign w_im = nz_r[n_d1_r] ? wk_rd_r[2*PROD_W-1:PROD_W] : '0;
  assign kn   = 12'(cmd.bin) * 12'(n_d1_r);
  assign tw_m = 6'(kn << STEP_SH);
  assign tw_c = cas_cos(tw_m);
  assign tw_s = cas_cos(tw_m + 6'd48);

  always_ff @(posedge clk) begin
    t_rc_r <= TERM_W'(w_re * tw_c);
    t_is_r <= TERM_W'(w_im * tw_s);
    t_ic_r <= TERM_W'(w_im * tw_c);
    t_rs_r <= TERM_W'(w_re * tw_s);
  end

  // pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
    end
  end

  // bin accumulators and rounding
  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      xr_r <= '0;
      xi_r <= '0;
    end else if (v2_r) begin
      xr_r <= xr_r + ACC_W'(t_rc_r) + ACC_W'(t_is_r);
      xi_r <= xi_r + ACC_W'(t_ic_r) - ACC_W'(t_rs_r);
    end
    if (cmd.rnd) begin
      mr_r <= round_mag(xr_r);
      mi_r <= round_mag(xi_r);
    end
  end

  // shift-add multiplier, one operand bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_acc_r <= '0;
      case (cmd.mul_sel)
        MUL_DEN: begin
          mul_a_r <= WIDE_W'(ref_energy);
          mul_b_r <= MAG_W'(held_r);
        end
        MUL_RE: begin
          mul_a_r <= WIDE_W'(mr_r);
          mul_b_r <= mr_r;
        end
        MUL_IM: begin
          mul_a_r <= WIDE_W'(mi_r);
          mul_b_r <= mi_r;
        end
        default: begin
          mul_a_r <= '0;
          mul_b_r <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mul_b_r[0]) begin
        mul_acc_r <= mul_acc_r + mul_a_r;
      end
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  // denominator and power
  always_ff @(posedge clk) begin
    if (cmd.den_save) begin
      den_r <= mul_acc_r;
    end
    if (cmd.p_save) begin
      p_r <= mul_acc_r;
    end else if (cmd.p_add) begin
      p_r <= p_r + mul_acc_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= p_r;
      quo_r <= '0;
      sat_r <= p_r >= den_r;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= WIDE_W'(rem_sh - {1'b0, den_r});
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= WIDE_W'(rem_sh);
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_r  <= cmd.bin;
      last_r <= cmd.bin_last;
      zero_r <= den_r == '0;
      if (den_r == '0) begin
        amb_r <= '0;
      end else if (sat_r) begin
        amb_r <= '1;
      end else begin
        amb_r <= quo_r;
      end
    end
  end

  assign sts.pos_ok   = pos_ok;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_bin_index   = bin_r;
  assign out_ambiguity   = amb_r;
  assign out_zero_energy = zero_r;
  assign out_last_bin    = last_r;

endmodule

// ===== src/cas_ctrl.sv =====
// controller state machine sequencing loads, dft, multiplies and divides
module cas_ctrl import cas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  input  logic     in_end_of_window,
  output logic     in_ready,
  input  cas_sts_t sts,
  output cas_cmd_t cmd
);

  cas_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic             eow_r, eow_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bin_r   <= '0;
      eow_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bin_r   <= bin_nxt;
      eow_r   <= eow_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    bin_nxt      = bin_r;
    eow_nxt      = eow_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.bin      = bin_r;
    cmd.bin_last = bin_r == BIN_W'(DFT_LEN - 1);
    cmd.mac_addr = cnt_r[ADDR_W-1:0];
    cmd.mul_sel  = MUL_DEN;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          eow_nxt     = in_end_of_window;
          if (in_op) begin
            if (sts.pos_ok) begin
              state_nxt = ST_PROD;
            end else if (in_end_of_window) begin
              state_nxt = ST_DEN;
              cnt_nxt   = '0;
            end
          end
        end
      end
      ST_PROD: begin
        cmd.prod_wr = 1'b1;
        if (eow_r) begin
          state_nxt = ST_DEN;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DEN: begin
        cmd.mul_sel = MUL_DEN;
        if (cnt_r == '0) begin
          cmd.mul_load = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (cnt_r == CNT_W'(MUL_STEPS + 1)) begin
          cmd.den_save = 1'b1;
          bin_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_MAC;
        end else begin
          cmd.mul_step = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
      end
      ST_MAC: begin
        cmd.mac_clr   = cnt_r == '0;
        cmd.mac_issue = cnt_r < CNT_W'(DFT_LEN);
        if (cnt_r == CNT_W'(DFT_LEN + 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RND;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_sel = MUL_RE;
        if (cnt_r == '0) begin
          cmd.mul_load = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (cnt_r == CNT_W'(MUL_STEPS + 1)) begin
          cmd.p_save = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_SQI;
        end else begin
          cmd.mul_step = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
      end
      ST_SQI: begin
        cmd.mul_sel = MUL_IM;
        if (cnt_r == '0) begin
          cmd.mul_load = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (cnt_r == CNT_W'(MUL_STEPS + 1)) begin
          cmd.p_add = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cmd.mul_step = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt_r == CNT_W'(QUO_W)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cnt_nxt      = '0;
          if (cmd.bin_last) begin
            state_nxt = ST_IDLE;
          end else begin
            bin_nxt   = bin_r + BIN_W'(1);
            state_nxt = ST_MAC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cross_ambiguity_surface_row_core.sv =====
// top level of the cross ambiguity surface row core
//
// Input channel (in_*): valid/ready items. op 0 loads one cutout sample at
// the running position, op 1 delivers one window sample, which is multiplied
// by the stored cutout sample. end_of_window returns the position to zero;
// on a window sample it also latches window_energy and starts the transform.
// Load items and window samples past the transform length are taken in the
// idle state alone; a window sample that forms a product also passes through
// the product-write state. After the last window sample the block computes
// the energy product, then for each bin a direct dft over the stored products
// through one multiply-accumulate pipe, rounding, two serial squarings and a
// 16-step restoring divide.
// Results (out_*) leave one item per bin from a result register; a stalled
// receiver holds the current item while the next bin is computed, and the
// block waits only when that next bin is ready and the register is full.
// Input is not taken while a window is being transformed.
// Reset (rst_n, synchronous) clears control state and sets reference_energy
// to 1; sample stores are undefined until written.
// reference_energy is written through the apb-style port at any address with paddr[3] clear.
module cross_ambiguity_surface_row_core import cas_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic signed [SAMPLE_W-1:0] in_sample_re,
  input  logic signed [SAMPLE_W-1:0] in_sample_im,
  input  logic [ENERGY_W-1:0]        in_window_energy,
  input  logic                       in_end_of_window,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [BIN_W-1:0]           out_bin_index,
  output logic [QUO_W-1:0]           out_ambiguity,
  output logic                       out_zero_energy,
  output logic                       out_last_bin,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  cas_cmd_t            cmd;
  cas_sts_t            sts;
  logic [ENERGY_W-1:0] ref_energy;

  // configuration registers
  cas_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ref_energy (ref_energy)
  );

  // sequencing
  cas_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_op            (in_op),
    .in_end_of_window (in_end_of_window),
    .in_ready         (in_ready),
    .sts              (sts),
    .cmd              (cmd)
  );

  // arithmetic and storage
  cas_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_sample_re     (in_sample_re),
    .in_sample_im     (in_sample_im),
    .in_window_energy (in_window_energy),
    .in_end_of_window (in_end_of_window),
    .ref_energy       (ref_energy),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_bin_index    (out_bin_index),
    .out_ambiguity    (out_ambiguity),
    .out_zero_energy  (out_zero_energy),
    .out_last_bin     (out_last_bin)
  );

`ifndef SYNTHESIS
  // a zero denominator forces the ambiguity to zero
  a_zero_amb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_zero_energy || out_ambiguity == '0))
    else $error("zero energy result with nonzero ambiguity");

  // a closing window sample starts the transform, input stops
  a_win_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op && in_end_of_window |=> !in_ready)
    else $error("input taken right after window end");

  // early bins leave while the transform is still running
  a_bin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_bin_index < BIN_W'(DFT_LEN - 2)) |=> !in_ready)
    else $error("input taken before all bins were produced");
`endif

endmodule

// ===== dv/tb_cross_ambiguity_surface_row_core.sv =====
// testbench for the cross ambiguity surface row core: table plus random items, scored on a predictor
`timescale 1ns / 1ps

module tb_cross_ambiguity_surface_row_core;
  import cas_pkg::*;

  localparam logic [3:0] REG_REF_ENERGY = 4'd0;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_ITEMS   = 320;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef enum logic {OP_LOAD = 1'b0, OP_WINDOW = 1'b1} op_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_ZERO, EXP_SAT} exp_kind_t;

  typedef struct {
    op_t                   op;
    logic signed [15:0]    re;
    logic signed [15:0]    im;
    logic [ENERGY_W-1:0]   energy;
    logic                  eow;
    exp_kind_t             kind;
  } sample_item_t;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [15:0]      amb;
    logic             zero;
    logic             last;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample_re = '0;
  logic signed [SAMPLE_W-1:0] in_sample_im = '0;
  logic [ENERGY_W-1:0] in_window_energy = '0;
  logic in_end_of_window = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BIN_W-1:0] out_bin_index;
  logic [QUO_W-1:0] out_ambiguity;
  logic out_zero_energy;
  logic out_last_bin;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  cross_ambiguity_surface_row_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0]  cut_re [DFT_LEN];
  logic signed [15:0]  cut_im [DFT_LEN];
  bit                  cut_written [DFT_LEN];
  longint              prod_re [DFT_LEN];
  longint              prod_im [DFT_LEN];
  int                  position;
  logic [ENERGY_W-1:0] ref_energy;

  bin_result_t expected_bins [$];
  int errors = 0;
  int items_sent = 0;
  int windows_sent = 0;
  int bins_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  // q1.14 cosine over the full circle
  function automatic longint twiddle_cos(int m);
    int q [17] = '{16384, 16305, 16069, 15679, 15137, 14449, 13623, 12665, 11585,
                   10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};
    m = m & 63;
    if (m <= 16) return q[m];
    if (m <= 32) return -q[32 - m];
    if (m <= 48) return -q[m - 32];
    return q[64 - m];
  endfunction

  function automatic longint unsigned round_drop14(longint acc);
    longint unsigned mag;
    mag = (acc < 0) ? longint'(-acc) : acc;
    return (mag + 64'd8192) >> 14;
  endfunction

  // advance the predictor by one item and queue the bins it produces
  task automatic predict_item(sample_item_t it);
    logic [127:0] denom, power;
    longint xr, xi, c, s;
    longint unsigned mr, mi;
    bin_result_t r;
    int step;
    step = 64 / DFT_LEN;
    if (position < DFT_LEN) begin
      if (it.op == OP_LOAD) begin
        cut_re[position] = it.re;
        cut_im[position] = it.im;
        cut_written[position] = 1'b1;
      end else begin
        prod_re[position] = longint'(it.re) * cut_re[position] - longint'(it.im) * cut_im[position];
        prod_im[position] = longint'(it.re) * cut_im[position] + longint'(it.im) * cut_re[position];
      end
      position++;
    end
    if (it.eow && it.op == OP_WINDOW) begin
      for (int n = position; n < DFT_LEN; n++) begin
        prod_re[n] = 0;
        prod_im[n] = 0;
      end
      denom = 128'(ref_energy) * 128'(it.energy);
      for (int k = 0; k < DFT_LEN; k++) begin
        xr = 0;
        xi = 0;
        for (int n = 0; n < DFT_LEN; n++) begin
          c = twiddle_cos((k * n * step) & 63);
          s = twiddle_cos(((k * n * step) & 63) + 48);
          xr += prod_re[n] * c + prod_im[n] * s;
          xi += prod_im[n] * c - prod_re[n] * s;
        end
        mr = round_drop14(xr);
        mi = round_drop14(xi);
        power = 128'(mr) * 128'(mr) + 128'(mi) * 128'(mi);
        r.bin = BIN_W'(k);
        r.last = (k == DFT_LEN - 1);
        if (denom == 0) begin
          r.amb = 16'd0;
          r.zero = 1'b1;
        end else begin
          r.amb = (power >= denom) ? 16'hFFFF : 16'((power << 16) / denom);
          r.zero = 1'b0;
        end
        // hand-written expectations for the obvious rows
        if (it.kind == EXP_ZERO) begin
          r.amb = 16'd0;
          r.zero = 1'b1;
        end else if (it.kind == EXP_SAT) begin
          r.amb = 16'hFFFF;
          r.zero = 1'b0;
        end
        expected_bins.push_back(r);
      end
      windows_sent++;
    end
    if (it.eow) position = 0;
  endtask

  // drive one item, with bursts and random gaps
  task automatic send_item(sample_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    predict_item(it);
    in_valid <= 1'b1;
    in_op <= it.op;
    in_sample_re <= it.re;
    in_sample_im <= it.im;
    in_window_energy <= it.energy;
    in_end_of_window <= it.eow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic finish_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ref_energy(logic [ENERGY_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_REF_ENERGY;
    pwdata <= 64'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ref_energy = value;
  endtask

  function automatic logic [ENERGY_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ENERGY_MAX;
      2, 3: return ENERGY_W'({$urandom, $urandom});
      default: return ENERGY_W'($urandom_range(1, 32'hFFFF_FFFF)) << $urandom_range(0, 5);
    endcase
  endfunction

  function automatic sample_item_t rand_sample(op_t op, logic eow);
    sample_item_t it;
    it.op = op;
    it.re = 16'($urandom);
    it.im = 16'($urandom);
    it.energy = pick_energy();
    it.eow = eow;
    it.kind = EXP_MODEL;
    return it;
  endfunction

  // directed rows: extremes, zero and saturated energy, mixed op, short window
  sample_item_t directed [] = '{
    '{OP_LOAD,    16'sh7FFF, 16'sh8000, 37'd5, 1'b0, EXP_MODEL},
    '{OP_LOAD,    16'sh8000, 16'sh7FFF, 37'd0, 1'b0, EXP_MODEL},
    '{OP_LOAD,    16'sh0000, 16'shFFFF, 37'd0, 1'b0, EXP_MODEL},
    '{OP_LOAD,    16'shFFFF, 16'sh0000, ENERGY_MAX, 1'b1, EXP_MODEL},
    '{OP_WINDOW,  16'sh7FFF, 16'sh7FFF, ENERGY_MAX, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'sh8000, 16'sh8000, 37'd0, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'sh0001, 16'shFFFF, 37'd7, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'shFFFF, 16'sh0001, 37'd0, 1'b1, EXP_ZERO},
    '{OP_WINDOW,  16'sh8000, 16'sh7FFF, 37'd0, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'sh7FFF, 16'sh8000, 37'd0, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'sh1234, 16'shEDCB, 37'd0, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'sh8000, 16'sh8000, ENERGY_MAX, 1'b1, EXP_MODEL},
    '{OP_WINDOW,  16'sh7FFF, 16'sh7FFF, 37'd1, 1'b1, EXP_SAT},
    '{OP_LOAD,    16'sh4000, 16'shC000, 37'd0, 1'b1, EXP_MODEL},
    '{OP_WINDOW,  16'sh3000, 16'sh0100, 37'd0, 1'b0, EXP_MODEL},
    '{OP_LOAD,    16'sh7FFF, 16'sh0000, 37'd0, 1'b0, EXP_MODEL},
    '{OP_WINDOW,  16'shC000, 16'sh2000, 37'h1_0000_0000, 1'b1, EXP_MODEL}
  };

  // result scoreboard
  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_valid && out_ready) begin
      bins_seen++;
      if (expected_bins.size() == 0) begin
        $error("unexpected result item, bin_index %0d", out_bin_index);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (out_bin_index !== e.bin) begin
          $error("bin_index: expected %0d actual %0d", e.bin, out_bin_index);
          errors++;
        end
        if (out_ambiguity !== e.amb) begin
          $error("ambiguity: expected %0d actual %0d", e.amb, out_ambiguity);
          errors++;
        end
        if (out_zero_energy !== e.zero) begin
          $error("zero_energy: expected %0d actual %0d", e.zero, out_zero_energy);
          errors++;
        end
        if (out_last_bin !== e.last) begin
          $error("last_bin: expected %0d actual %0d", e.last, out_last_bin);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: stretches of full rate and stretches of random stalls
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 15) > 11);
    endcase
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [ENERGY_W-1:0] phase_energy [3];
    sample_item_t it;
    int phase_items, win_len, reload_len;
    position = 0;
    ref_energy = 37'd1;
    for (int i = 0; i < DFT_LEN; i++) cut_written[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run on the reset value of reference_energy
    foreach (directed[i]) send_item(directed[i]);
    finish_stream();

    phase_energy[0] = ENERGY_MAX;
    phase_energy[1] = '0;
    phase_energy[2] = ENERGY_W'($urandom_range(1, 32'hFFFF_FFFF)) << 4;
    for (int ph = 0; ph < 3; ph++) begin
      write_ref_energy(phase_energy[ph]);
      phase_items = 0;
      // fresh full cutout
      for (int n = 0; n < DFT_LEN; n++) begin
        send_item(rand_sample(OP_LOAD, n == DFT_LEN - 1));
        phase_items++;
      end
      while (phase_items < RANDOM_ITEMS / 3) begin
        case ($urandom_range(0, 9))
          0: win_len = $urandom_range(65, 70);
          1: win_len = DFT_LEN;
          default: win_len = $urandom_range(1, 16);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          // partial cutout reload, or a stray load ending a sequence
          reload_len = $urandom_range(1, 12);
          for (int n = 0; n < reload_len; n++) begin
            send_item(rand_sample(OP_LOAD, n == reload_len - 1));
            phase_items++;
          end
        end
        for (int n = 0; n < win_len; n++) begin
          it = rand_sample(OP_WINDOW, n == win_len - 1);
          if ($urandom_range(0, 19) == 0) it.op = OP_LOAD;
          if (position < DFT_LEN && !cut_written[position]) it.op = OP_LOAD;
          send_item(it);
          phase_items++;
        end
      end
      finish_stream();
    end

    write_ref_energy(37'd1);
    finish_stream();
    $display("covered %0d input items over %0d windows and %0d result bins,", items_sent,
             windows_sent, bins_seen);
    $display("with reference energy at one, zero, full scale and a random value");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cas_pkg.sv
src/cas_regs.sv
src/cas_datapath.sv
src/cas_ctrl.sv
src/cross_ambiguity_surface_row_core.sv
dv/tb_cross_ambiguity_surface_row_core.sv
